// ===== design/vlk_pkg.sv =====
// Shared types, widths and the rounding helper for the look-at view matrix block.
package vlk_pkg;

    typedef logic signed [31:0] t_word;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned IN_DATA_W = 9 * WORD_W;
    localparam int unsigned OUT_DATA_W = 12 * WORD_W;
    localparam int unsigned NORM_CW_DFLT = 64;
    localparam int unsigned NORM_PW_DFLT = 6 * WORD_W;
    localparam int unsigned CROSS_PW_DFLT = 6 * WORD_W;

    // floor((x + 2^29) / 2^30), saturated to a signed 32-bit word.
    function automatic t_word round_sat(input logic signed [67:0] x);
        logic signed [67:0] y;
        logic signed [67:0] q;
        t_word r;
        y = x + 68'sd536870912;
        q = y >>> 30;
        if (q > 68'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (q < -68'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/vlk_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root and divide.
module vlk_norm
    import vlk_pkg::*;
#(
    parameter int unsigned CW = NORM_CW_DFLT,
    parameter int unsigned PW = NORM_PW_DFLT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_c [3],
    input  logic [PW-1:0]        i_pay,
    output logic                 o_vld,
    output t_word                o_r [3],
    output logic [PW-1:0]        o_pay
);

    localparam int unsigned PBW = $clog2(CW);
    localparam int unsigned SW = PW + 4 + 90;
    localparam int unsigned DW = PW + 4;
    localparam int unsigned LAT = 70;

    function automatic logic [PBW-1:0] lead(input logic [CW-1:0] x);
        logic [PBW-1:0] p;
        p = '0;
        for (int i = 0; i < CW; i++) begin
            if (x[i]) begin
                p = PBW'(i);
            end
        end
        return p;
    endfunction

    logic [LAT-1:0] r_vld;

    // Stage 0: magnitudes and signs.
    logic [CW-1:0] r_a0 [3];
    logic [2:0]    r_neg0;
    logic [PW-1:0] r_pay0;
    // Stage 1: position of the leading one over all three magnitudes.
    logic [CW-1:0]  r_a1 [3];
    logic [PBW-1:0] r_p1;
    logic           r_z1;
    logic [2:0]     r_neg1;
    logic [PW-1:0]  r_pay1;
    // Stage 2: common scaling so the largest lies in [2^29, 2^30).
    logic [29:0]   r_a2 [3];
    logic          r_z2;
    logic [2:0]    r_neg2;
    logic [PW-1:0] r_pay2;
    // Stage 3: squares.
    logic [59:0]   r_sq3 [3];
    logic [29:0]   r_a3 [3];
    logic          r_z3;
    logic [2:0]    r_neg3;
    logic [PW-1:0] r_pay3;

    logic [63:0]   r_n   [33];
    logic [63:0]   r_res [33];
    logic [SW-1:0] r_sd  [33];

    logic [59:0]   r_num [3][32];
    logic [30:0]   r_q   [3][32];
    logic [31:0]   r_len [32];
    logic [DW-1:0] r_dsd [32];

    t_word         r_out [3];
    logic [PW-1:0] r_opay;

    logic [CW-1:0]  any_mag;
    logic [PBW-1:0] rsh;
    logic [PBW-1:0] lsh;
    logic [29:0]    n_a2 [3];

    assign any_mag = r_a0[0] | r_a0[1] | r_a0[2];
    assign rsh = r_p1 - PBW'(29);
    assign lsh = PBW'(29) - r_p1;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_p1 >= PBW'(29)) begin
                n_a2[l] = 30'(r_a1[l] >> rsh);
            end else begin
                n_a2[l] = 30'(r_a1[l] << lsh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_a0[l]   <= i_c[l][CW-1] ? CW'(-i_c[l]) : CW'(i_c[l]);
                r_neg0[l] <= i_c[l][CW-1];
                r_a1[l]   <= r_a0[l];
                r_a2[l]   <= n_a2[l];
                r_sq3[l]  <= r_a2[l] * r_a2[l];
                r_a3[l]   <= r_a2[l];
            end
            r_pay0 <= i_pay;
            r_p1   <= lead(any_mag);
            r_z1   <= (any_mag == '0);
            r_neg1 <= r_neg0;
            r_pay1 <= r_pay0;
            r_z2   <= r_z1;
            r_neg2 <= r_neg1;
            r_pay2 <= r_pay1;
            r_z3   <= r_z2;
            r_neg3 <= r_neg2;
            r_pay3 <= r_pay2;
            r_n[0]   <= 64'(r_sq3[0]) + 64'(r_sq3[1]) + 64'(r_sq3[2]);
            r_res[0] <= '0;
            r_sd[0]  <= {r_pay3, r_z3, r_neg3, r_a3[2], r_a3[1], r_a3[0]};
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] sq_t;
        assign sq_t = r_res[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_n[k] >= sq_t) begin
                    r_n[k+1]   <= r_n[k] - sq_t;
                    r_res[k+1] <= (r_res[k] >> 1) + BIT;
                end else begin
                    r_n[k+1]   <= r_n[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_num[l][0] <= {r_sd[32][l*30 +: 30], 30'd0};
                r_q[l][0]   <= '0;
            end
            r_len[0] <= r_res[32][31:0];
            r_dsd[0] <= r_sd[32][SW-1:90];
        end
    end

    // Restoring division, one quotient bit per stage and lane.
    for (genvar j = 0; j < 31; j++) begin : g_div
        logic [61:0] dv_d;
        assign dv_d = {30'd0, r_len[j]} << (30 - j);
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic ge;
            logic [61:0] diff;
            assign ge = {2'b00, r_num[l][j]} >= dv_d;
            assign diff = {2'b00, r_num[l][j]} - dv_d;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[l][j+1] <= ge ? diff[59:0] : r_num[l][j];
                    r_q[l][j+1]   <= {r_q[l][j][29:0], ge};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[j+1] <= r_len[j];
                r_dsd[j+1] <= r_dsd[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                if (r_dsd[31][3]) begin
                    r_out[l] <= '0;
                end else if (r_dsd[31][l]) begin
                    r_out[l] <= -$signed({1'b0, r_q[l][31]});
                end else begin
                    r_out[l] <= $signed({1'b0, r_q[l][31]});
                end
            end
            r_opay <= r_dsd[31][DW-1:4];
        end
    end

    assign o_vld = r_vld[LAT-1];
    assign o_r   = r_out;
    assign o_pay = r_opay;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_vld)
        else $error("normalizer valid survived reset");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_r[0] <= 32'sd1073741824 && o_r[0] >= -32'sd1073741824 &&
                   o_r[1] <= 32'sd1073741824 && o_r[1] >= -32'sd1073741824 &&
                   o_r[2] <= 32'sd1073741824 && o_r[2] >= -32'sd1073741824))
        else $error("normalized component above one");
    a_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !r_z2) |-> (r_a2[0][29] || r_a2[1][29] || r_a2[2][29]))
        else $error("scaling left the largest component below 2^29");

endmodule

// ===== design/vlk_cross.sv =====
// Two-stage exact cross product of two vectors of signed words.
module vlk_cross
    import vlk_pkg::*;
#(
    parameter int unsigned PW = CROSS_PW_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_word              i_p [3],
    input  t_word              i_q [3],
    input  logic [PW-1:0]      i_pay,
    output logic               o_vld,
    output logic signed [63:0] o_r [3],
    output logic [PW-1:0]      o_pay
);

    logic [1:0]         r_vld;
    logic signed [63:0] r_pr [6];
    logic [PW-1:0]      r_pay1;
    logic signed [63:0] r_r [3];
    logic [PW-1:0]      r_pay2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr[0] <= i_p[1] * i_q[2];
            r_pr[1] <= i_p[2] * i_q[1];
            r_pr[2] <= i_p[2] * i_q[0];
            r_pr[3] <= i_p[0] * i_q[2];
            r_pr[4] <= i_p[0] * i_q[1];
            r_pr[5] <= i_p[1] * i_q[0];
            r_pay1  <= i_pay;
            r_r[0]  <= r_pr[0] - r_pr[1];
            r_r[1]  <= r_pr[2] - r_pr[3];
            r_r[2]  <= r_pr[4] - r_pr[5];
            r_pay2  <= r_pay1;
        end
    end

    assign o_vld = r_vld[1];
    assign o_r   = r_r;
    assign o_pay = r_pay2;

endmodule

// ===== design/vlk_dot.sv =====
// Rounds v and forms the three saturated translations; holds the output register.
module vlk_dot
    import vlk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [63:0] i_wu [3],
    input  t_word              i_u [3],
    input  t_word              i_w [3],
    input  t_word              i_eye [3],
    output logic               o_vld,
    output t_word              o_rows [9],
    output t_word              o_sh [3]
);

    logic [3:0]         r_vld;
    t_word              r_rows0 [9];
    t_word              r_eye0 [3];
    logic signed [63:0] r_pr [9];
    t_word              r_rows1 [9];
    logic signed [65:0] r_sum [3];
    t_word              r_rows2 [9];
    t_word              r_rows3 [9];
    t_word              r_sh [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rows0[l]     <= i_u[l];
                r_rows0[3 + l] <= round_sat(68'(i_wu[l]));
                r_rows0[6 + l] <= i_w[l];
                r_eye0[l]      <= i_eye[l];
            end
            for (int r = 0; r < 3; r++) begin
                for (int l = 0; l < 3; l++) begin
                    r_pr[3*r + l] <= r_rows0[3*r + l] * r_eye0[l];
                end
                r_sum[r] <= 66'(r_pr[3*r]) + 66'(r_pr[3*r + 1]) + 66'(r_pr[3*r + 2]);
                r_sh[r]  <= round_sat(-68'(r_sum[r]));
            end
            r_rows1 <= r_rows0;
            r_rows2 <= r_rows1;
            r_rows3 <= r_rows2;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_rows = r_rows3;
    assign o_sh   = r_sh;

endmodule

// ===== design/view_matrix_look_at.sv =====
// Top level of the look-at view matrix pipeline.
//
// Usage: one transfer on the slave stream carries an eye point, a focus point
// and an up vector (signed Q16.16). One transfer on the master stream returns
// the rows u, v, w in signed Q2.30 and the translations -u.eye, -v.eye,
// -w.eye in Q16.16, saturated.
// The path from the input transfer to o_m_tvalid runs through a register
// for eye - focus, two normalizers (32 square-root stages and 31 divide
// stages each, plus scaling), two cross products and the rounding and dot
// product stages. Throughput is one item per cycle while the receiver does not
// stall; the normalizers' square-root and divide stages are fully pipelined.
// Reset clears every valid bit; data registers are not reset.
// When the receiver stalls, the whole pipeline holds: o_s_tready falls while
// a result waits and i_m_tready is low, and nothing is lost or repeated.
// A zero eye - focus gives an all-zero matrix; an up vector parallel to w
// gives zero u and v rows.
module view_matrix_look_at
    import vlk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // eye_x, eye_y, eye_z, focus_x, focus_y, focus_z, up_x, up_y, up_z
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // right_x/y/z, upward_x/y/z, back_x/y/z, shift_0, shift_1, shift_2
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic               en;
    logic               r_dv;
    logic signed [32:0] r_d [3];
    t_word              r_eye [3];
    t_word              r_up [3];

    logic               nw_vld;
    t_word              nw_w [3];
    logic [191:0]       nw_pay;
    logic [191:0]       nw_in_pay;
    t_word              c1_up [3];

    logic               c1_vld;
    logic signed [63:0] c1_r [3];
    logic [191:0]       c1_pay;
    logic [191:0]       c1_in_pay;

    logic               nu_vld;
    t_word              nu_u [3];
    logic [191:0]       nu_pay;

    logic               c2_vld;
    logic signed [63:0] c2_r [3];
    logic [287:0]       c2_pay;
    logic [287:0]       c2_in_pay;
    t_word              c2_w [3];

    t_word              dt_u [3];
    t_word              dt_w [3];
    t_word              dt_eye [3];
    t_word              dt_rows [9];
    t_word              dt_sh [3];

    // The output register sits at the end of the dot stage; everything
    // advances together whenever it is empty or being taken.
    assign en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (en) begin
            r_dv <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_eye[l] <= i_s_tdata[32*l +: 32];
                r_up[l]  <= i_s_tdata[32*(6 + l) +: 32];
                r_d[l]   <= 33'($signed(i_s_tdata[32*l +: 32]))
                          - 33'($signed(i_s_tdata[32*(3 + l) +: 32]));
            end
        end
    end

    assign nw_in_pay = {r_up[2], r_up[1], r_up[0], r_eye[2], r_eye[1], r_eye[0]};

    vlk_norm #(.CW(33), .PW(192)) u_norm_w (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_dv),
        .i_c    (r_d),
        .i_pay  (nw_in_pay),
        .o_vld  (nw_vld),
        .o_r    (nw_w),
        .o_pay  (nw_pay)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c1_up[l] = nw_pay[96 + 32*l +: 32];
        end
    end
    assign c1_in_pay = {nw_w[2], nw_w[1], nw_w[0], nw_pay[95:0]};

    vlk_cross #(.PW(192)) u_cross_uw (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (nw_vld),
        .i_p    (c1_up),
        .i_q    (nw_w),
        .i_pay  (c1_in_pay),
        .o_vld  (c1_vld),
        .o_r    (c1_r),
        .o_pay  (c1_pay)
    );

    vlk_norm #(.CW(64), .PW(192)) u_norm_u (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (c1_vld),
        .i_c    (c1_r),
        .i_pay  (c1_pay),
        .o_vld  (nu_vld),
        .o_r    (nu_u),
        .o_pay  (nu_pay)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c2_w[l] = nu_pay[96 + 32*l +: 32];
        end
    end
    assign c2_in_pay = {nu_u[2], nu_u[1], nu_u[0], nu_pay};

    vlk_cross #(.PW(288)) u_cross_wu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (nu_vld),
        .i_p    (c2_w),
        .i_q    (nu_u),
        .i_pay  (c2_in_pay),
        .o_vld  (c2_vld),
        .o_r    (c2_r),
        .o_pay  (c2_pay)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            dt_eye[l] = c2_pay[32*l +: 32];
            dt_w[l]   = c2_pay[96 + 32*l +: 32];
            dt_u[l]   = c2_pay[192 + 32*l +: 32];
        end
    end

    vlk_dot u_dot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (c2_vld),
        .i_wu   (c2_r),
        .i_u    (dt_u),
        .i_w    (dt_w),
        .i_eye  (dt_eye),
        .o_vld  (o_m_tvalid),
        .o_rows (dt_rows),
        .o_sh   (dt_sh)
    );

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            o_m_tdata[32*i +: 32] = dt_rows[i];
        end
        for (int i = 0; i < 3; i++) begin
            o_m_tdata[32*(9 + i) +: 32] = dt_sh[i];
        end
    end

endmodule

// ===== test/vlk_checker.sv =====
// Checker for the look-at view matrix block: predicts each result and compares it.
`timescale 1ns / 1ps
module vlk_checker
    import vlk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_matrix_count
);

    typedef logic signed [63:0] t_q64;
    typedef logic signed [127:0] t_wide;

    logic [OUT_DATA_W-1:0] view_queue[$];
    int fail_count = 0;
    int matrix_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = view_queue.size();
    assign o_matrix_count = matrix_count;

    function automatic logic [63:0] magnitude(input t_q64 x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bit_val;
        root = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > n) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (n >= root + bit_val) begin
                n = n - (root + bit_val);
                root = (root >> 1) + bit_val;
            end else begin
                root = root >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return root;
    endfunction

    // Scale the magnitudes together so the largest lies in [2^29, 2^30), then divide.
    function automatic void normalize(input t_q64 c[3], output t_q64 r[3]);
        logic [63:0] mags[3];
        logic [63:0] peak;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] quot;
        peak = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mags[i] = magnitude(c[i]);
            if (mags[i] > peak) peak = mags[i];
        end
        if (peak == 0) begin
            for (int i = 0; i < 3; i++) r[i] = 0;
            return;
        end
        while (peak >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mags[i] = mags[i] >> 1;
            peak = peak >> 1;
        end
        while (peak < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mags[i] = mags[i] << 1;
            peak = peak << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mags[i] * mags[i];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            quot = (mags[i] << 30) / len;
            r[i] = c[i] < 0 ? -t_q64'(quot) : t_q64'(quot);
        end
    endfunction

    function automatic t_word round_q30(input t_wide x);
        t_wide y;
        y = (x + t_wide'(64'sd536870912)) >>> 30;
        if (y > t_wide'(64'sd2147483647)) return 32'sh7fff_ffff;
        if (y < -t_wide'(64'sd2147483648)) return 32'sh8000_0000;
        return t_word'(y[31:0]);
    endfunction

    function automatic t_word neg_dot(input t_q64 row[3], input t_q64 eye[3]);
        t_wide acc;
        acc = t_wide'(row[0]) * t_wide'(eye[0]) + t_wide'(row[1]) * t_wide'(eye[1])
            + t_wide'(row[2]) * t_wide'(eye[2]);
        return round_q30(-acc);
    endfunction

    function automatic logic [OUT_DATA_W-1:0] predict_view(input logic [IN_DATA_W-1:0] d);
        t_q64 eye[3], focus[3], up[3], diff[3], back[3], uxw[3], right[3], upward[3];
        t_wide wxu;
        logic [OUT_DATA_W-1:0] packed_view;
        for (int i = 0; i < 3; i++) begin
            eye[i] = t_q64'(t_word'(d[32*i +: 32]));
            focus[i] = t_q64'(t_word'(d[32*(3+i) +: 32]));
            up[i] = t_q64'(t_word'(d[32*(6+i) +: 32]));
            diff[i] = eye[i] - focus[i];
        end
        normalize(diff, back);
        uxw[0] = up[1] * back[2] - up[2] * back[1];
        uxw[1] = up[2] * back[0] - up[0] * back[2];
        uxw[2] = up[0] * back[1] - up[1] * back[0];
        normalize(uxw, right);
        for (int i = 0; i < 3; i++) begin
            wxu = t_wide'(back[(i+1)%3]) * t_wide'(right[(i+2)%3])
                - t_wide'(back[(i+2)%3]) * t_wide'(right[(i+1)%3]);
            upward[i] = t_q64'(round_q30(wxu));
        end
        for (int i = 0; i < 3; i++) begin
            packed_view[32*i +: 32] = right[i][31:0];
            packed_view[32*(3+i) +: 32] = upward[i][31:0];
            packed_view[32*(6+i) +: 32] = back[i][31:0];
        end
        packed_view[32*9 +: 32] = neg_dot(right, eye);
        packed_view[32*10 +: 32] = neg_dot(upward, eye);
        packed_view[32*11 +: 32] = neg_dot(back, eye);
        return packed_view;
    endfunction

    task automatic report_mismatch(input string what, input int field,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %0s field %0d: got %h, expected %h", what, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic [OUT_DATA_W-1:0] want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) view_queue.push_back(predict_view(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                matrix_count++;
                if (view_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0, 0);
                end else begin
                    want = view_queue.pop_front();
                    for (int f = 0; f < 12; f++)
                        if (i_m_tdata[32*f +: 32] !== want[32*f +: 32])
                            report_mismatch("matrix", f, i_m_tdata[32*f +: 32], want[32*f +: 32]);
                end
            end
        end
    end

endmodule

// ===== test/tb_view_matrix_look_at.sv =====
// Testbench top for the look-at view matrix block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_view_matrix_look_at;
    import vlk_pkg::*;

    localparam int LATENCY = 149;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    int fail_count, pending, matrix_count;
    int cycles = 0;
    int stall_mode = 0;

    view_matrix_look_at i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    vlk_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_matrix_count(matrix_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // The receiver runs in phases: always ready, occasional stalls, or frequent stalls.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 3) != 0;
            default: m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
        endcase
    end

    function automatic t_word random_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(0, 2)) << $urandom_range(0, 31);
            2: return -t_word'($urandom_range(0, 65535) << 8);
            3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return t_word'($signed($urandom_range(0, 20000)) - 10000) <<< 16;
        endcase
    endfunction

    // With no gap, tvalid stays high so the next transfer follows directly.
    task automatic send_view(input t_word eye[3], input t_word focus[3], input t_word up[3]);
        logic [IN_DATA_W-1:0] word;
        int gap;
        for (int i = 0; i < 3; i++) begin
            word[32*i +: 32] = eye[i];
            word[32*(3+i) +: 32] = focus[i];
            word[32*(6+i) +: 32] = up[i];
        end
        s_tdata <= word;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_scalars(input t_word ex, ey, ez, fx, fy, fz, ux, uy, uz);
        t_word e[3], f[3], u[3];
        e = '{ex, ey, ez};
        f = '{fx, fy, fz};
        u = '{ux, uy, uz};
        send_view(e, f, u);
    endtask

    initial begin
        t_word e[3], f[3], u[3];
        localparam t_word ONE = 32'sh0001_0000;
        localparam t_word MAXW = 32'sh7fff_ffff;
        localparam t_word MINW = 32'sh8000_0000;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: plain camera, eye equals focus, up zero or parallel, field extremes.
        send_scalars(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
        send_scalars(3 * ONE, ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 0, ONE, 0);
        send_scalars(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0);
        send_scalars(0, 0, 4 * ONE, 0, 0, 0, 0, 0, 7 * ONE);
        send_scalars(0, 0, 4 * ONE, 0, 0, 0, 0, 0, -ONE);
        send_scalars(MAXW, MAXW, MAXW, MINW, MINW, MINW, MAXW, MINW, MAXW);
        send_scalars(MINW, MINW, MINW, MAXW, MAXW, MAXW, MINW, MAXW, MINW);
        send_scalars(MAXW, MINW, MAXW, 0, 0, 0, 1, 0, 0);
        send_scalars(MINW, 0, 0, MAXW, 0, 0, 0, MINW, 0);
        send_scalars(1, 0, 0, 0, 0, 0, 0, 1, 0);
        send_scalars(-1, -1, -1, 0, 0, 0, 0, 0, 1);
        send_scalars(-1, -1, -1, 0, 0, 0, -1, -1, -1);
        send_scalars(MAXW, MAXW, MAXW, 0, 0, 0, MINW, MAXW, 1);
        send_scalars(MINW, MINW, MINW, 0, 0, 0, -1, 0, 0);
        send_scalars(-1, 0, 0, -1, 0, 0, MAXW, MAXW, MAXW);
        s_tvalid <= 1'b0;

        // Hold off until the pipeline has drained completely.
        wait (pending == 0);
        @(negedge i_clk);

        for (int n = 0; n < 500; n++) begin
            for (int i = 0; i < 3; i++) begin
                e[i] = random_word();
                f[i] = ($urandom_range(0, 19) == 0) ? e[i] : random_word();
                u[i] = random_word();
            end
            if ($urandom_range(0, 24) == 0) u = '{e[0] - f[0], e[1] - f[1], e[2] - f[2]};
            send_view(e, f, u);
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (LATENCY + 20) @(negedge i_clk);
        $display("covered %0d matrices: directed camera and degenerate cases,", matrix_count);
        $display("then random views with receiver stall phases and sender gaps");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== view_matrix_look_at.f =====
design/vlk_pkg.sv
design/vlk_norm.sv
design/vlk_cross.sv
design/vlk_dot.sv
design/view_matrix_look_at.sv
test/vlk_checker.sv
test/tb_view_matrix_look_at.sv
